FILE: hdl/brp_pkg.sv
// Shared types and constants for the backscatter removal pixel core.
// Holds the stage map of the pipeline, the per-lane stage record and the
// configuration register indexes. Depends on nothing.
`default_nettype none

package brp_pkg;

  // Color lanes, processed side by side in every stage.
  localparam int NUM_LANES  = 3;
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_VEIL_BLUE   = 3'd0;
  localparam cfg_idx_t REG_VEIL_GREEN  = 3'd1;
  localparam cfg_idx_t REG_VEIL_RED    = 3'd2;
  localparam cfg_idx_t REG_ATTEN_BLUE  = 3'd3;
  localparam cfg_idx_t REG_ATTEN_GREEN = 3'd4;
  localparam cfg_idx_t REG_ATTEN_RED   = 3'd5;
  localparam cfg_idx_t REG_BG_RANGE    = 3'd6;

  localparam logic [14:0] BG_RANGE_RST = 15'd5120;  // 20.0 m in Q7.8

  // Fixed-point constants of the exponential.
  localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [11:0] EXP_BIG   = 12'd17;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  // Stage map. Each series term after the first takes three stages:
  // multiply by t, reciprocal multiply, then quotient fix-up and accumulate.
  localparam int ST_ENTRY     = 0;
  localparam int ST_LOG       = 1;
  localparam int ST_LN        = 2;
  localparam int ST_SERIES    = 3;
  localparam int SERIES_TERMS = 11;
  localparam int ST_EXP       = ST_SERIES + 3 * SERIES_TERMS;
  localparam int ST_VEIL      = ST_EXP + 1;
  localparam int ST_OUT       = ST_VEIL + 1;
  localparam int NUM_STAGES   = ST_OUT + 1;

  // Scaling of the reciprocal used for the division by a term index.
  localparam int RECIP_SHIFT = 35;

  // Per-lane contents of one pipeline stage. Fields are reused from stage
  // to stage; what each holds is given next to the stage that writes it.
  typedef struct packed {
    logic [15:0] pix;   // intensity, then corrected result
    logic [31:0] t;     // reduced exponent f*ln2, Q0.32
    logic [31:0] term;  // current series term or intermediate product
    logic [31:0] aux;   // scratch: fraction, quotient estimate, backscatter
    logic [32:0] acc;   // series sum, Q1.32
    logic        big;   // exponent too large, transmission is zero
    logic [4:0]  n;     // integer part of the base-2 exponent
  } lane_t;

endpackage

`default_nettype wire

FILE: hdl/backscatter_removal_pixel_core.sv
// Top level of the backscatter removal pixel core: configuration registers
// and the 39-stage elastic pipeline that corrects one pixel per word.
// Depends on brp_pkg.
`default_nettype none

// The pipeline accepts a new pixel word every cycle as long as the output side
// keeps up. Its depth comes from the exp(-x) unit: range times attenuation, a
// change to base 2, then a series where each of the eleven terms after the first
// costs a multiply, a reciprocal multiply for the division by the term index
// and a fix-up, followed by the final shift, the veil multiply and the clamp.
// Every stage carries its own valid bit and takes new data whenever it is
// empty or its successor moves, so bubbles collapse and a stalled output only
// holds back words behind it once the stages between are full. Configuration
// words are taken every cycle and must only be written while the pipeline is
// empty.
module backscatter_removal_pixel_core (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_blue_in,
  input  logic [15:0]       in_green_in,
  input  logic [15:0]       in_red_in,
  input  logic signed [15:0] in_range_m,
  // corrected pixel output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_blue_out,
  output logic [15:0]       out_green_out,
  output logic [15:0]       out_red_out,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  brp_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data
);

  import brp_pkg::*;

  logic [15:0] veil_r  [NUM_LANES];
  logic [15:0] atten_r [NUM_LANES];
  logic [14:0] bg_range_r;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] adv;
  lane_t                 pipe_r   [NUM_STAGES][NUM_LANES];
  lane_t                 pipe_nxt [NUM_STAGES][NUM_LANES];

  logic [15:0] pix_in [NUM_LANES];
  logic [14:0] z;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        veil_r[i]  <= '0;
        atten_r[i] <= '0;
      end
      bg_range_r <= BG_RANGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VEIL_BLUE:   veil_r[LANE_BLUE]   <= cfg_data;
        REG_VEIL_GREEN:  veil_r[LANE_GREEN]  <= cfg_data;
        REG_VEIL_RED:    veil_r[LANE_RED]    <= cfg_data;
        REG_ATTEN_BLUE:  atten_r[LANE_BLUE]  <= cfg_data;
        REG_ATTEN_GREEN: atten_r[LANE_GREEN] <= cfg_data;
        REG_ATTEN_RED:   atten_r[LANE_RED]   <= cfg_data;
        REG_BG_RANGE:    bg_range_r          <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Entry selection.
  // ---------------------------------------------------------------------
  assign pix_in[LANE_BLUE]  = in_blue_in;
  assign pix_in[LANE_GREEN] = in_green_in;
  assign pix_in[LANE_RED]   = in_red_in;

  // A range that is zero or negative is replaced by the background range.
  assign z = (!in_range_m[15] && (in_range_m != 16'sd0)) ? in_range_m[14:0] : bg_range_r;

  // ---------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its contents move on.
  // ---------------------------------------------------------------------
  assign adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;

  for (genvar s = 0; s < NUM_STAGES - 1; s++) begin : g_adv
    assign adv[s] = !valid_r[s] || adv[s+1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (adv[s]) begin
          valid_r[s] <= (s == 0) ? in_valid : valid_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (adv[s]) begin
        for (int c = 0; c < NUM_LANES; c++) begin
          pipe_r[s][c] <= pipe_nxt[s][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage logic.
  // ---------------------------------------------------------------------
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stg
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane

      if (s == ST_ENTRY) begin : g_entry
        // Exponent p = atten * z, Q.20.
        logic [30:0] p;
        assign p = 31'(atten_r[c]) * 31'(z);
        always_comb begin
          pipe_nxt[s][c]      = '0;
          pipe_nxt[s][c].pix  = pix_in[c];
          pipe_nxt[s][c].term = {1'b0, p};
        end

      end else if (s == ST_LOG) begin : g_log
        // Base-2 exponent: integer part n and 32 bits of fraction.
        logic [62:0] y;
        assign y = 63'(pipe_r[s-1][c].term[30:0]) * 63'(LOG2E_Q31);
        always_comb begin
          pipe_nxt[s][c]     = pipe_r[s-1][c];
          pipe_nxt[s][c].big = (y[62:51] >= EXP_BIG);
          pipe_nxt[s][c].n   = y[55:51];
          pipe_nxt[s][c].aux = y[50:19];
        end

      end else if (s == ST_LN) begin : g_ln
        // Back to a natural exponent t in [0, ln2); first term of the series.
        logic [63:0] prod;
        assign prod = 64'(pipe_r[s-1][c].aux) * 64'(LN2_Q32);
        always_comb begin
          pipe_nxt[s][c]      = pipe_r[s-1][c];
          pipe_nxt[s][c].t    = prod[63:32];
          pipe_nxt[s][c].term = prod[63:32];
          pipe_nxt[s][c].acc  = ONE_Q32 - {1'b0, prod[63:32]};
        end

      end else if (s < ST_EXP) begin : g_series
        localparam int K     = (s - ST_SERIES) / 3 + 2;
        localparam int PHASE = (s - ST_SERIES) % 3;
        localparam logic [34:0] RECIP = 35'((64'd1 << RECIP_SHIFT) / K);

        if (PHASE == 0) begin : g_mul
          logic [63:0] prod;
          assign prod = 64'(pipe_r[s-1][c].term) * 64'(pipe_r[s-1][c].t);
          always_comb begin
            pipe_nxt[s][c]      = pipe_r[s-1][c];
            pipe_nxt[s][c].term = prod[63:32];
          end

        end else if (PHASE == 1) begin : g_recip
          // Quotient estimate that is low by at most one.
          logic [66:0] prod;
          assign prod = 67'(pipe_r[s-1][c].term) * 67'(RECIP);
          always_comb begin
            pipe_nxt[s][c]     = pipe_r[s-1][c];
            pipe_nxt[s][c].aux = prod[66:35];
          end

        end else begin : g_fix
          logic [35:0] kq;
          logic [35:0] rem;
          logic [31:0] q;
          assign kq  = 36'(pipe_r[s-1][c].aux) * 36'(K);
          assign rem = 36'(pipe_r[s-1][c].term) - kq;
          assign q   = pipe_r[s-1][c].aux + 32'(rem >= 36'(K));
          always_comb begin
            pipe_nxt[s][c]      = pipe_r[s-1][c];
            pipe_nxt[s][c].term = q;
            if ((K % 2) == 1) begin
              pipe_nxt[s][c].acc = pipe_r[s-1][c].acc - 33'(q);
            end else begin
              pipe_nxt[s][c].acc = pipe_r[s-1][c].acc + 33'(q);
            end
          end
        end

      end else if (s == ST_EXP) begin : g_exp
        // Scale by 2^-n with rounding to Q0.16.
        logic [5:0]  sh;
        logic [33:0] sum;
        logic [33:0] scaled;
        assign sh     = 6'(pipe_r[s-1][c].n) + 6'd16;
        assign sum    = {1'b0, pipe_r[s-1][c].acc} + (34'd1 << (sh - 6'd1));
        assign scaled = sum >> sh;
        always_comb begin
          pipe_nxt[s][c]      = pipe_r[s-1][c];
          pipe_nxt[s][c].term = pipe_r[s-1][c].big ? 32'd0 : 32'(scaled[16:0]);
        end

      end else if (s == ST_VEIL) begin : g_veil
        // Backscatter veil * (1 - e), rounded to Q1.15.
        logic [32:0] prod;
        logic [32:0] rnd;
        assign prod = 33'(veil_r[c]) * 33'(ONE_Q16 - pipe_r[s-1][c].term[16:0]);
        assign rnd  = prod + 33'd32768;
        always_comb begin
          pipe_nxt[s][c]     = pipe_r[s-1][c];
          pipe_nxt[s][c].aux = 32'(rnd[31:16]);
        end

      end else begin : g_out
        logic [15:0] bs;
        assign bs = pipe_r[s-1][c].aux[15:0];
        always_comb begin
          pipe_nxt[s][c]     = pipe_r[s-1][c];
          pipe_nxt[s][c].pix = (pipe_r[s-1][c].pix > bs) ? (pipe_r[s-1][c].pix - bs) : 16'd0;
        end
      end

    end
  end

  assign out_valid     = valid_r[ST_OUT];
  assign out_blue_out  = pipe_r[ST_OUT][LANE_BLUE].pix;
  assign out_green_out = pipe_r[ST_OUT][LANE_GREEN].pix;
  assign out_red_out   = pipe_r[ST_OUT][LANE_RED].pix;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // Input back-pressure only appears once every stage holds a word.
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&valid_r))
    else $error("input stalled while the pipeline had an empty stage");

  // The series sum never rises above one.
  a_series_bound : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_EXP-1] |->
      (pipe_r[ST_EXP-1][LANE_BLUE].acc  <= ONE_Q32) &&
      (pipe_r[ST_EXP-1][LANE_GREEN].acc <= ONE_Q32) &&
      (pipe_r[ST_EXP-1][LANE_RED].acc   <= ONE_Q32))
    else $error("exponential series sum exceeds one");

  // The transmission stays within [0, 1] in Q0.16.
  a_trans_bound : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_EXP] |->
      (pipe_r[ST_EXP][LANE_BLUE].term  <= 32'(ONE_Q16)) &&
      (pipe_r[ST_EXP][LANE_GREEN].term <= 32'(ONE_Q16)) &&
      (pipe_r[ST_EXP][LANE_RED].term   <= 32'(ONE_Q16)))
    else $error("transmission above one");

endmodule

`default_nettype wire

FILE: tb/backscatter_removal_pixel_checker.sv
// Checker for the backscatter removal pixel core: watches the pixel, result and
// configuration channels, predicts each corrected word and compares it.
// Depends on brp_pkg for the register indexes, lane numbers and reset range.
module backscatter_removal_pixel_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       in_blue_in,
  input  logic [15:0]       in_green_in,
  input  logic [15:0]       in_red_in,
  input  logic [15:0]       in_range_m,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_blue_out,
  input  logic [15:0]       out_green_out,
  input  logic [15:0]       out_red_out,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  brp_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                compared
);
  import brp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LOG2E_FRAC = 64'd3098164009;  // log2(e), Q1.31
  localparam logic [63:0] LN2_FRAC   = 64'd2977044472;  // ln(2), Q0.32
  localparam logic [63:0] UNITY_Q32  = 64'd1 << 32;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  logic [15:0] veil [3];
  logic [15:0] atten [3];
  logic [14:0] bg_range;
  rgb_t        corrected_q[$];

  initial begin
    errors   = 0;
    pending  = 0;
    compared = 0;
  end

  // exp(-atten * z) in Q0.16, 65536 meaning full transmission.
  function automatic logic [16:0] transmission_q16(logic [15:0] coef, logic [14:0] z);
    logic [63:0] y, whole, t, acc, term;
    int k;
    y     = (64'(coef) * 64'(z)) * LOG2E_FRAC;
    whole = y >> 51;
    if (whole >= 64'd17) return 17'd0;
    t    = (((y & ((64'd1 << 51) - 64'd1)) >> 19) * LN2_FRAC) >> 32;
    acc  = UNITY_Q32;
    term = UNITY_Q32;
    for (k = 1; k <= 12; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return 17'((acc + (64'd1 << (whole + 15))) >> (whole + 16));
  endfunction

  function automatic logic [15:0] remove_veil(logic [15:0] level, int lane, logic [14:0] z);
    logic [63:0] scatter;
    scatter = (64'(veil[lane]) * (64'd65536 - 64'(transmission_q16(atten[lane], z)))
               + 64'd32768) >> 16;
    return (64'(level) > scatter) ? 16'(64'(level) - scatter) : 16'd0;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [14:0] z;
    rgb_t        want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        veil[i]  = 16'd0;
        atten[i] = 16'd0;
      end
      bg_range = BG_RANGE_RST;
      corrected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VEIL_BLUE:   veil[LANE_BLUE]   = cfg_data;
          REG_VEIL_GREEN:  veil[LANE_GREEN]  = cfg_data;
          REG_VEIL_RED:    veil[LANE_RED]    = cfg_data;
          REG_ATTEN_BLUE:  atten[LANE_BLUE]  = cfg_data;
          REG_ATTEN_GREEN: atten[LANE_GREEN] = cfg_data;
          REG_ATTEN_RED:   atten[LANE_RED]   = cfg_data;
          REG_BG_RANGE:    bg_range          = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        // A zero or negative range falls back to the background range.
        z = (in_range_m == 16'd0 || in_range_m[15]) ? bg_range : in_range_m[14:0];
        want.blue  = remove_veil(in_blue_in, LANE_BLUE, z);
        want.green = remove_veil(in_green_in, LANE_GREEN, z);
        want.red   = remove_veil(in_red_in, LANE_RED, z);
        corrected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (corrected_q.size() == 0) begin
          report_error($sformatf("result word %h %h %h with none expected",
                                 out_blue_out, out_green_out, out_red_out));
        end else begin
          want = corrected_q.pop_front();
          compared++;
          if (out_blue_out !== want.blue)
            report_error($sformatf("blue got %h, expected %h", out_blue_out, want.blue));
          if (out_green_out !== want.green)
            report_error($sformatf("green got %h, expected %h", out_green_out, want.green));
          if (out_red_out !== want.red)
            report_error($sformatf("red got %h, expected %h", out_red_out, want.red));
        end
      end
    end
    pending = corrected_q.size();
  end

endmodule

FILE: tb/backscatter_removal_pixel_core_test.sv
// Top of the backscatter removal pixel core testbench: clock, reset, pixel and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on brp_pkg, backscatter_removal_pixel_core and the pixel checker.
module backscatter_removal_pixel_core_test;
  import brp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam cfg_idx_t REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [15:0]       in_blue_in, in_green_in, in_red_in;
  logic signed [15:0] in_range_m;
  logic              out_valid;
  logic              out_ready;
  logic [15:0]       out_blue_out, out_green_out, out_red_out;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_idx_t          cfg_index;
  logic [15:0]       cfg_data;

  int errors, pending, compared;
  int pixels_sent = 0;
  int settings = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  backscatter_removal_pixel_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_blue_in, .in_green_in, .in_red_in, .in_range_m,
    .out_valid, .out_ready, .out_blue_out, .out_green_out, .out_red_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  backscatter_removal_pixel_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_blue_in, .in_green_in, .in_red_in,
    .in_range_m(in_range_m),
    .out_valid, .out_ready, .out_blue_out, .out_green_out, .out_red_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .compared
  );

  // Result side: a random number of stalled cycles before each word.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [15:0] b, g, r, rng);
    int gap;
    // Switch between back-to-back streaming and bursty traffic now and then.
    if (pixels_sent % 50 == 0) begin
      case ($urandom_range(0, 2))
        0: in_gap_max = 0;
        1: in_gap_max = 4;
        default: in_gap_max = 17;
      endcase
      case ($urandom_range(0, 2))
        0: out_gap_max = 0;
        1: out_gap_max = 4;
        default: out_gap_max = 17;
      endcase
    end
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_blue_in  <= b;
    in_green_in <= g;
    in_red_in   <= r;
    in_range_m  <= rng;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // Registers only change once every word in flight has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] vb, vg, vr, ab, ag, ar, bgr);
    wait_idle();
    write_reg(REG_VEIL_BLUE, vb);
    write_reg(REG_VEIL_GREEN, vg);
    write_reg(REG_VEIL_RED, vr);
    write_reg(REG_ATTEN_BLUE, ab);
    write_reg(REG_ATTEN_GREEN, ag);
    write_reg(REG_ATTEN_RED, ar);
    write_reg(REG_BG_RANGE, bgr);
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, 16'($urandom));
    settings++;
  endtask

  function automatic logic [15:0] pick_veil();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Attenuations mostly stay below 2 per metre so the exponent is not always huge.
  function automatic logic [15:0] pick_atten();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 255));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h2000));
    endcase
  endfunction

  function automatic logic [15:0] pick_bg();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 16'h0A00));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'($urandom_range(16'h8000, 16'hFFFF));
      2: return 16'($urandom);
      3: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(1, 16'h0A00));
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(pick_level(), pick_level(), pick_level(), pick_range());
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_blue_in  = 16'd0;
    in_green_in = 16'd0;
    in_red_in   = 16'd0;
    in_range_m  = 16'sd0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_VEIL_BLUE;
    cfg_data    = 16'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: no veil, so every pixel passes through unchanged.
    send_pixel(16'hFFFF, 16'h0000, 16'hAAAA, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h5555, 16'h7FFF);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'h8000);

    // Zero background range makes an invalid range mean full transmission;
    // the red attenuation at its maximum drives the exponent out of range.
    load_regs(16'h8000, 16'hFFFF, 16'h4000, 16'h0100, 16'h1000, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0100);
    send_pixel(16'h1234, 16'hABCD, 16'h5555, 16'h0A00);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0100);
    send_pixel(16'h0001, 16'h0001, 16'h0001, 16'h0200);

    // The top data bit of the background range write must be dropped.
    wait_idle();
    write_reg(REG_BG_RANGE, 16'hFFFF);
    write_reg(REG_ATTEN_RED, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    settings++;
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0080);
    send_pixel(16'h5555, 16'hAAAA, 16'h0000, 16'h4000);

    // Every register at its top value: transmission drops to zero for all but short ranges.
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_random(40);

    for (int p = 0; p < 8; p++) begin
      load_regs(pick_veil(), pick_veil(), pick_veil(),
                pick_atten(), pick_atten(), pick_atten(), pick_bg());
      send_random(195);
    end

    wait_idle();
    repeat (50) @(negedge clk);
    $display("covered %0d pixels over %0d register settings, %0d corrected words compared",
             pixels_sent, settings, compared);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
